### hw/rtl/bpic_pkg.sv
// shared types and constants of the baseline pic instruction core
package bpic_pkg;

    // storage sizes
    localparam int REG_COUNT   = 32;
    localparam int STACK_DEPTH = 2;
    localparam int RF_AW       = $clog2(REG_COUNT);

    // field widths
    localparam int INSTR_W = 12;
    localparam int ADDR_W  = 5;
    localparam int PC_W    = 9;
    localparam int DATA_W  = 8;
    localparam int ERR_W   = 2;

    // special file addresses
    localparam logic [ADDR_W-1:0] F_INDF   = 5'd0;
    localparam logic [ADDR_W-1:0] F_PCL    = 5'd2;
    localparam logic [ADDR_W-1:0] F_STATUS = 5'd3;
    localparam logic [ADDR_W-1:0] F_FSR    = 5'd4;
    localparam logic [ADDR_W-1:0] F_GPIO   = 5'd6;

    // reset values
    localparam logic [DATA_W-1:0] PCL_RST    = 8'hff;
    localparam logic [DATA_W-1:0] STATUS_RST = 8'h18;
    localparam logic [DATA_W-1:0] FSR_RST    = 8'he0;
    localparam logic [DATA_W-1:0] FILE5_RST  = 8'hfe;
    localparam logic [DATA_W-1:0] TRIS_RST   = 8'h3f;
    localparam logic [DATA_W-1:0] OPTION_RST = 8'hff;

    // error codes
    localparam logic [ERR_W-1:0] ERR_NONE        = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNSUPPORTED = 2'd1;
    localparam logic [ERR_W-1:0] ERR_OPCODE      = 2'd2;

    // fixed register file taps and the indexed read
    typedef struct packed {
        logic [DATA_W-1:0] pcl;
        logic [DATA_W-1:0] status;
        logic [DATA_W-1:0] fsr;
        logic [DATA_W-1:0] gpio;
        logic [DATA_W-1:0] rd_data;
    } bpic_rf_view_t;

    // next state produced by the execute logic
    typedef struct packed {
        logic [ERR_W-1:0]  err;
        logic              two;
        logic              rf_we;
        logic [ADDR_W-1:0] rf_waddr;
        logic [DATA_W-1:0] rf_wdata;
        logic [DATA_W-1:0] pcl;
        logic              pc_high;
        logic [DATA_W-1:0] status;
        logic [DATA_W-1:0] w;
        logic [DATA_W-1:0] tris;
        logic [DATA_W-1:0] option;
        logic              push;
        logic              pop;
        logic [PC_W-1:0]   push_data;
    } bpic_upd_t;

endpackage

### hw/rtl/bpic_regfile.sv
// register file with fixed taps, one indexed read, one indexed write port and direct pcl and status writes
module bpic_regfile (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          exec,
    input  bpic_pkg::bpic_upd_t           upd,
    input  logic [bpic_pkg::ADDR_W-1:0]   rd_addr,
    output bpic_pkg::bpic_rf_view_t       view
);
    import bpic_pkg::*;

    logic [DATA_W-1:0] rf_reg  [REG_COUNT];
    logic [DATA_W-1:0] rf_next [REG_COUNT];

    function automatic logic [DATA_W-1:0] reset_value(input int idx);
        logic [DATA_W-1:0] v;
        v = '0;
        if (idx == int'(F_PCL))
            v = PCL_RST;
        else if (idx == int'(F_STATUS))
            v = STATUS_RST;
        else if (idx == int'(F_FSR))
            v = FSR_RST;
        else if (idx == 5)
            v = FILE5_RST;
        return v;
    endfunction

    // next value of every entry
    always_comb
    begin
        for (int i = 0; i < REG_COUNT; i++)
        begin
            rf_next[i] = rf_reg[i];
            if (exec)
            begin
                if (i == int'(F_PCL))
                    rf_next[i] = upd.pcl;
                else if (i == int'(F_STATUS))
                    rf_next[i] = upd.status;
                else if (upd.rf_we && upd.rf_waddr == ADDR_W'(i))
                    rf_next[i] = upd.rf_wdata;
            end
        end
    end

    // storage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
                rf_reg[i] <= reset_value(i);
        end
        else
        begin
            for (int i = 0; i < REG_COUNT; i++)
                rf_reg[i] <= rf_next[i];
        end
    end

    // taps and indexed read, zero beyond the implemented entries
    always_comb
    begin
        view.pcl    = rf_reg[F_PCL[RF_AW-1:0]];
        view.status = rf_reg[F_STATUS[RF_AW-1:0]];
        view.fsr    = rf_reg[F_FSR[RF_AW-1:0]];
        view.gpio   = rf_reg[F_GPIO[RF_AW-1:0]];
        if (int'(rd_addr) < REG_COUNT)
            view.rd_data = rf_reg[rd_addr[RF_AW-1:0]];
        else
            view.rd_data = '0;
    end

endmodule

### hw/rtl/bpic_stack.sv
// return address stack, push shifts down and pop shifts up
module bpic_stack (
    input  logic                        clk,
    input  logic                        push,
    input  logic                        pop,
    input  logic [bpic_pkg::PC_W-1:0]   push_data,
    output logic [bpic_pkg::PC_W-1:0]   top
);
    import bpic_pkg::*;

    logic [PC_W-1:0] stack_reg  [STACK_DEPTH];
    logic [PC_W-1:0] stack_next [STACK_DEPTH];

    // shift network
    always_comb
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
            stack_next[i] = stack_reg[i];
        if (push)
        begin
            for (int i = 1; i < STACK_DEPTH; i++)
                stack_next[i] = stack_reg[i-1];
            stack_next[0] = push_data;
        end
        else if (pop)
        begin
            for (int i = 0; i < STACK_DEPTH - 1; i++)
                stack_next[i] = stack_reg[i+1];
        end
    end

    // entries hold return addresses only, no reset needed
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < STACK_DEPTH; i++)
            stack_reg[i] <= stack_next[i];
    end

    assign top = stack_reg[0];

endmodule

### hw/rtl/bpic_exec.sv
// instruction decode, alu and next state computation
module bpic_exec (
    input  logic [bpic_pkg::INSTR_W-1:0] instr,
    input  logic [bpic_pkg::DATA_W-1:0]  w,
    input  logic [bpic_pkg::DATA_W-1:0]  tris,
    input  logic [bpic_pkg::DATA_W-1:0]  option,
    input  logic                         pc_high,
    input  logic [bpic_pkg::PC_W-1:0]    stack_top,
    input  bpic_pkg::bpic_rf_view_t      view,
    output logic [bpic_pkg::ADDR_W-1:0]  rd_addr,
    output bpic_pkg::bpic_upd_t          upd
);
    import bpic_pkg::*;

    localparam logic [DATA_W-1:0] FLAG_C  = 8'h01;
    localparam logic [DATA_W-1:0] FLAG_DC = 8'h02;
    localparam logic [DATA_W-1:0] FLAG_Z  = 8'h04;

    logic [ADDR_W-1:0] f;
    logic              d;
    logic [ADDR_W-1:0] addr;
    logic              addr_ok;
    logic [PC_W-1:0]   pc_cur;
    logic [PC_W-1:0]   pc_inc;
    logic [PC_W-1:0]   pc_skip;
    logic [PC_W-1:0]   pc_jump;
    logic [PC_W-1:0]   pc_seq;
    logic [PC_W-1:0]   pc_fin;
    logic [DATA_W-1:0] mem;
    logic [ERR_W-1:0]  err;
    logic [DATA_W-1:0] res;
    logic              has_res;
    logic              wr_want;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] w_new;
    logic [DATA_W-1:0] tris_new;
    logic [DATA_W-1:0] opt_new;
    logic [DATA_W-1:0] fmask;
    logic [DATA_W-1:0] fval;
    logic              skip;
    logic              jump;
    logic              push;
    logic              pop;
    logic [DATA_W:0]   sum9;
    logic [DATA_W:0]   diff9;
    logic [4:0]        nib_sum;
    logic [DATA_W-1:0] bit_mask;
    logic [DATA_W-1:0] k;
    logic [DATA_W-1:0] lit_res;
    logic              wr_ok;
    logic              pcl_wr;
    logic              st_wr;
    logic [DATA_W-1:0] status_fin;

    // operand address, indirect through fsr
    assign f       = instr[ADDR_W-1:0];
    assign d       = instr[5];
    assign addr    = (f == F_INDF) ? view.fsr[ADDR_W-1:0] : f;
    assign addr_ok = (addr != F_INDF) && (int'(addr) < REG_COUNT);
    assign rd_addr = addr;

    // program counter candidates
    assign pc_cur  = {pc_high, view.pcl};
    assign pc_inc  = pc_cur + PC_W'(1);
    assign pc_skip = pc_cur + PC_W'(2);

    // file operand: gpio reads pins, pcl reads the already advanced value
    always_comb
    begin
        if (!addr_ok)
            mem = '0;
        else if (addr == F_GPIO)
            mem = 8'h08 | ((view.gpio | tris) & 8'h37);
        else if (addr == F_PCL)
            mem = pc_inc[DATA_W-1:0];
        else
            mem = view.rd_data;
    end

    // error classification of the low control space
    always_comb
    begin
        err = ERR_NONE;
        if (instr[INSTR_W-1:ADDR_W] == '0)
        begin
            if (f == F_STATUS || f == F_FSR)
                err = ERR_UNSUPPORTED;
            else if (f != F_INDF && f != F_PCL && f != F_GPIO)
                err = ERR_OPCODE;
        end
    end

    assign sum9     = {1'b0, mem} + {1'b0, w};
    assign diff9    = {1'b0, mem} - {1'b0, w};
    assign nib_sum  = {1'b0, mem[3:0]} + {1'b0, w[3:0]};
    assign bit_mask = DATA_W'(1) << instr[7:5];
    assign k        = instr[DATA_W-1:0];

    // decode and execute
    always_comb
    begin
        res      = '0;
        has_res  = 1'b0;
        wr_want  = 1'b0;
        wdata    = '0;
        w_new    = w;
        tris_new = tris;
        opt_new  = option;
        fmask    = '0;
        fval     = '0;
        skip     = 1'b0;
        jump     = 1'b0;
        pc_jump  = '0;
        push     = 1'b0;
        pop      = 1'b0;
        lit_res  = '0;
        if (instr[11:10] == 2'b00)
        begin
            has_res = 1'b1;
            unique case (instr[9:6])
                4'h0:
                begin
                    has_res = 1'b0;
                    if (!d)
                    begin
                        if (f == F_PCL)
                            opt_new = w;
                        else if (f == F_GPIO)
                            tris_new = w;
                    end
                    else
                    begin
                        wr_want = 1'b1;
                        wdata   = w;
                    end
                end
                4'h1:
                begin
                    res   = '0;
                    fmask = FLAG_Z;
                    fval  = FLAG_Z;
                end
                4'h2:
                begin
                    res   = diff9[DATA_W-1:0];
                    fmask = FLAG_C | FLAG_DC | FLAG_Z;
                    fval  = ((mem >= w) ? FLAG_C : '0)
                          | ((mem[3:0] >= w[3:0]) ? FLAG_DC : '0)
                          | ((diff9[DATA_W-1:0] == '0) ? FLAG_Z : '0);
                end
                4'h3:
                begin
                    res   = mem - DATA_W'(1);
                    fmask = FLAG_Z;
                    fval  = (res == '0) ? FLAG_Z : '0;
                end
                4'h4:
                begin
                    res   = mem | w;
                    fmask = FLAG_Z;
                    fval  = (res == '0) ? FLAG_Z : '0;
                end
                4'h5:
                begin
                    res   = mem & w;
                    fmask = FLAG_Z;
                    fval  = (res == '0) ? FLAG_Z : '0;
                end
                4'h6:
                begin
                    res   = mem ^ w;
                    fmask = FLAG_Z;
                    fval  = (res == '0) ? FLAG_Z : '0;
                end
                4'h7:
                begin
                    res   = sum9[DATA_W-1:0];
                    fmask = FLAG_C | FLAG_DC | FLAG_Z;
                    fval  = (sum9[DATA_W] ? FLAG_C : '0)
                          | (nib_sum[4] ? FLAG_DC : '0)
                          | ((sum9[DATA_W-1:0] == '0) ? FLAG_Z : '0);
                end
                4'h8:
                begin
                    res   = mem;
                    fmask = FLAG_Z;
                    fval  = (res == '0) ? FLAG_Z : '0;
                end
                4'h9:
                begin
                    res   = ~mem;
                    fmask = FLAG_Z;
                    fval  = (res == '0) ? FLAG_Z : '0;
                end
                4'ha:
                begin
                    res   = mem + DATA_W'(1);
                    fmask = FLAG_Z;
                    fval  = (res == '0) ? FLAG_Z : '0;
                end
                4'hb:
                begin
                    res  = mem - DATA_W'(1);
                    skip = (res == '0);
                end
                4'hc:
                begin
                    res   = {view.status[0], mem[DATA_W-1:1]};
                    fmask = FLAG_C;
                    fval  = mem[0] ? FLAG_C : '0;
                end
                4'hd:
                begin
                    res   = {mem[DATA_W-2:0], view.status[0]};
                    fmask = FLAG_C;
                    fval  = mem[DATA_W-1] ? FLAG_C : '0;
                end
                4'he:
                begin
                    res = {mem[3:0], mem[7:4]};
                end
                default:
                begin
                    res  = mem + DATA_W'(1);
                    skip = (res == '0);
                end
            endcase
            if (has_res)
            begin
                if (d)
                begin
                    wr_want = 1'b1;
                    wdata   = res;
                end
                else
                begin
                    w_new = res;
                end
            end
        end
        else if (instr[11:10] == 2'b01)
        begin
            unique case (instr[9:8])
                2'b00:
                begin
                    wr_want = 1'b1;
                    wdata   = mem & ~bit_mask;
                end
                2'b01:
                begin
                    wr_want = 1'b1;
                    wdata   = mem | bit_mask;
                end
                2'b10:
                    skip = ((mem & bit_mask) == '0);
                default:
                    skip = ((mem & bit_mask) != '0);
            endcase
        end
        else
        begin
            unique case (instr[11:8])
                4'h8:
                begin
                    pop     = 1'b1;
                    jump    = 1'b1;
                    pc_jump = stack_top;
                    w_new   = k;
                end
                4'h9:
                begin
                    push    = 1'b1;
                    jump    = 1'b1;
                    pc_jump = {1'b0, k};
                end
                4'ha, 4'hb:
                begin
                    jump    = 1'b1;
                    pc_jump = {instr[8], k};
                end
                4'hc:
                    w_new = k;
                4'hd:
                begin
                    lit_res = w | k;
                    w_new   = lit_res;
                    fmask   = FLAG_Z;
                    fval    = (lit_res == '0) ? FLAG_Z : '0;
                end
                4'he:
                begin
                    lit_res = w & k;
                    w_new   = lit_res;
                    fmask   = FLAG_Z;
                    fval    = (lit_res == '0) ? FLAG_Z : '0;
                end
                default:
                begin
                    lit_res = w ^ k;
                    w_new   = lit_res;
                    fmask   = FLAG_Z;
                    fval    = (lit_res == '0) ? FLAG_Z : '0;
                end
            endcase
        end
    end

    // file write target, writes to pcl and status override the rest
    assign wr_ok      = wr_want && addr_ok;
    assign pcl_wr     = wr_ok && (addr == F_PCL);
    assign st_wr      = wr_ok && (addr == F_STATUS);
    assign pc_seq     = jump ? pc_jump : (skip ? pc_skip : pc_inc);
    assign pc_fin     = pcl_wr ? {1'b0, wdata} : pc_seq;
    assign status_fin = st_wr ? wdata : ((view.status & ~fmask) | (fval & fmask));

    // pack the update, an error holds every piece of state
    always_comb
    begin
        upd.err       = err;
        upd.rf_waddr  = addr;
        upd.rf_wdata  = wdata;
        upd.push_data = pc_inc;
        if (err == ERR_NONE)
        begin
            upd.two     = skip || jump || pcl_wr;
            upd.rf_we   = wr_ok && !pcl_wr && !st_wr;
            upd.pcl     = pc_fin[DATA_W-1:0];
            upd.pc_high = pc_fin[PC_W-1];
            upd.status  = status_fin;
            upd.w       = w_new;
            upd.tris    = tris_new;
            upd.option  = opt_new;
            upd.push    = push;
            upd.pop     = pop;
        end
        else
        begin
            upd.two     = 1'b0;
            upd.rf_we   = 1'b0;
            upd.pcl     = view.pcl;
            upd.pc_high = pc_high;
            upd.status  = view.status;
            upd.w       = w;
            upd.tris    = tris;
            upd.option  = option;
            upd.push    = 1'b0;
            upd.pop     = 1'b0;
        end
    end

endmodule

### hw/rtl/baseline_pic_instruction_core_unit.sv
// top level of the baseline pic instruction core
//
// Executes one 12-bit instruction word per input item and returns one result
// item per instruction. The caller fetches each word at the next_pc of the
// previous result; after reset the first fetch address is 0x1FF.
// Input channel: instruction with in_valid / in_stall. Output channel:
// next_pc, accumulator, pin_levels, two_cycle, error_code and option_bits
// with out_valid / out_stall.
// An accepted item passes through the input register, then through decode and
// execute into the result register.
// Throughput is one item per cycle while the receiver does not stall, set by
// the execute path from the register file and W back into themselves.
// While the receiver stalls the result register holds its item, the input
// register can still take one more item, and in_stall rises only once both
// are full.
// Reset clears both stages and loads the register file, W, TRIS, OPTION and
// the high pc bit with their power-on values; the return stack is not
// cleared and a return through a never-pushed entry is undefined.
module baseline_pic_instruction_core_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bpic_pkg::INSTR_W-1:0]  instruction,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bpic_pkg::PC_W-1:0]     next_pc,
    output logic [bpic_pkg::DATA_W-1:0]   accumulator,
    output logic [bpic_pkg::DATA_W-1:0]   pin_levels,
    output logic                          two_cycle,
    output logic [bpic_pkg::ERR_W-1:0]    error_code,
    output logic [bpic_pkg::DATA_W-1:0]   option_bits
);
    import bpic_pkg::*;

    logic               instr_valid_reg;
    logic [INSTR_W-1:0] instr_reg;
    logic               out_valid_reg;
    logic [PC_W-1:0]    next_pc_reg;
    logic [DATA_W-1:0]  acc_reg;
    logic [DATA_W-1:0]  pins_reg;
    logic               two_reg;
    logic [ERR_W-1:0]   err_reg;
    logic [DATA_W-1:0]  opt_out_reg;
    logic [DATA_W-1:0]  w_reg;
    logic [DATA_W-1:0]  tris_reg;
    logic [DATA_W-1:0]  option_reg;
    logic               pc_high_reg;

    logic               advance;
    logic               exec_fire;
    logic               in_take;
    logic [ADDR_W-1:0]  rd_addr;
    logic [PC_W-1:0]    stack_top;
    logic [DATA_W-1:0]  gpio_new;
    bpic_rf_view_t      view;
    bpic_upd_t          upd;

    // pipeline flow control
    assign advance   = !out_valid_reg || !out_stall;
    assign exec_fire = instr_valid_reg && advance;
    assign in_stall  = instr_valid_reg && !advance;
    assign in_take   = in_valid && !in_stall;

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            instr_valid_reg <= 1'b0;
        else if (!in_stall)
            instr_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            instr_reg <= instruction;
    end

    bpic_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .exec    (exec_fire),
        .upd     (upd),
        .rd_addr (rd_addr),
        .view    (view)
    );

    bpic_stack u_stack (
        .clk       (clk),
        .push      (exec_fire && upd.push),
        .pop       (exec_fire && upd.pop),
        .push_data (upd.push_data),
        .top       (stack_top)
    );

    bpic_exec u_exec (
        .instr     (instr_reg),
        .w         (w_reg),
        .tris      (tris_reg),
        .option    (option_reg),
        .pc_high   (pc_high_reg),
        .stack_top (stack_top),
        .view      (view),
        .rd_addr   (rd_addr),
        .upd       (upd)
    );

    // core state outside the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            w_reg       <= '0;
            tris_reg    <= TRIS_RST;
            option_reg  <= OPTION_RST;
            pc_high_reg <= 1'b1;
        end
        else if (exec_fire)
        begin
            w_reg       <= upd.w;
            tris_reg    <= upd.tris;
            option_reg  <= upd.option;
            pc_high_reg <= upd.pc_high;
        end
    end

    // pin levels after this item's write
    assign gpio_new = (upd.rf_we && upd.rf_waddr == F_GPIO) ? upd.rf_wdata : view.gpio;

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= instr_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (exec_fire)
        begin
            next_pc_reg <= {upd.pc_high, upd.pcl};
            acc_reg     <= upd.w;
            pins_reg    <= gpio_new | upd.tris;
            two_reg     <= upd.two;
            err_reg     <= upd.err;
            opt_out_reg <= upd.option;
        end
    end

    assign out_valid   = out_valid_reg;
    assign next_pc     = next_pc_reg;
    assign accumulator = acc_reg;
    assign pin_levels  = pins_reg;
    assign two_cycle   = two_reg;
    assign error_code  = err_reg;
    assign option_bits = opt_out_reg;

`ifndef SYNTH
    // an executed item always shows up as a result next cycle
    a_exec_to_result: assert property (@(posedge clk) disable iff (!rst_n)
        exec_fire |=> out_valid)
        else $error("executed item did not reach the result register");

    // an error leaves the program counter where it was
    a_err_holds_pc: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && upd.err != ERR_NONE) |=>
            ({pc_high_reg, view.pcl} == $past({pc_high_reg, view.pcl})))
        else $error("error item moved the program counter");

    // an error leaves W untouched
    a_err_holds_w: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && upd.err != ERR_NONE) |=> (w_reg == $past(w_reg)))
        else $error("error item changed W");

    // an error result never reports a dead cycle
    a_err_not_two: assert property (@(posedge clk) disable iff (!rst_n)
        (exec_fire && upd.err != ERR_NONE) |=> !two_cycle)
        else $error("error result flagged two cycles");
`endif

endmodule
